// ===== src/crc32_pkg.sv =====
// Package for the CRC-32 message check unit: polynomial, widths and the
// byte-wise remainder table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crc32_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CrcW  = 32;
  localparam int unsigned CntW  = 3;

  localparam logic [CrcW-1:0] CrcPoly = 32'h04C1_1DB7;
  localparam logic [CntW-1:0] CntFull = 3'd4;

  typedef logic [255:0][CrcW-1:0] crc_table_t;

  // Remainder of each top byte after eight MSB-first division steps.
  // Evaluated at elaboration only.
  function automatic crc_table_t build_table();
    crc_table_t tab;
    logic [CrcW-1:0] v;
    for (int t = 0; t < 256; t++) begin
      v = {t[7:0], 24'h0};
      for (int k = 0; k < 8; k++) begin
        if (v[CrcW-1]) begin
          v = {v[CrcW-2:0], 1'b0} ^ CrcPoly;
        end else begin
          v = {v[CrcW-2:0], 1'b0};
        end
      end
      tab[t] = v;
    end
    return tab;
  endfunction

  localparam crc_table_t CrcTable = build_table();

endpackage

`default_nettype wire

// ===== src/crc32_msb_first_message_check_unit.sv =====
// Top level of the CRC-32 (MSB first, polynomial 04C11DB7) message check.
// Uses crc32_pkg for the widths and the remainder table.
// An accepted last byte passes the input register and then the result register.
// Throughput: one byte per cycle while no last byte waits on a full result slot;
// the single table lookup on the top accumulator byte sets the per-byte step.
// Reset clears the accumulator, byte count and both stage valid flags.
`timescale 1ns / 1ps
`default_nettype none

module crc32_msb_first_message_check_unit (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire  [crc32_pkg::ByteW-1:0]    s_axis_tdata_i,  // data_byte [7:0]
  input  wire                            s_axis_tlast_i,  // last_byte
  output logic                           m_axis_tvalid_o,
  input  wire                            m_axis_tready_i,
  output logic [crc32_pkg::CrcW-1:0]     m_axis_tdata_o   // crc_value [31:0]
);
  import crc32_pkg::*;

  // Input register stage.
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;

  // Running state.
  logic [CrcW-1:0]  acc_q, acc_d;
  logic [CntW-1:0]  seen_q, seen_d;

  // Result register.
  logic             out_valid_q;
  logic [CrcW-1:0]  out_data_q, out_data_d;

  logic             advance;
  logic             in_take;
  logic             out_free;
  logic [CrcW-1:0]  word;
  logic [CrcW-1:0]  step;

  // The held byte waits only if last and its full result slot is not being read.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Byte shifted in from the bottom, and the table step for the top byte.
  assign word = {acc_q[CrcW-ByteW-1:0], in_byte_q};
  assign step = word ^ CrcTable[acc_q[CrcW-1 -: ByteW]];

  // Next accumulator, byte count and check value.
  always_comb begin
    acc_d      = acc_q;
    seen_d     = seen_q;
    out_data_d = ~step;
    if (!seen_q[CntW-1]) begin
      // Still gathering the first four bytes; short messages pad with zeros.
      case (seen_q[1:0])
        2'd0:    out_data_d = {word[7:0], 24'h0};
        2'd1:    out_data_d = {word[15:0], 16'h0};
        2'd2:    out_data_d = {word[23:0], 8'h0};
        default: out_data_d = word;
      endcase
      acc_d  = (seen_q[1:0] == 2'd3) ? ~word : word;
      seen_d = seen_q + CntW'(1);
    end else begin
      acc_d  = step;
      seen_d = CntFull;
    end
    if (in_last_q) begin
      acc_d  = '0;
      seen_d = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      seen_q      <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        acc_q  <= acc_d;
        seen_q <= seen_d;
      end
      if (advance && in_last_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (advance && in_last_q) begin
      out_data_q <= out_data_d;
    end
  end

`ifndef ASSERT_OFF
  // The byte count never passes four.
  a_seen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= CntFull)
    else $error("byte count above four");

  // A finished message always leaves a result behind.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> out_valid_q)
    else $error("last byte left no result");

  // A finished message restarts the count.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> seen_q == '0)
    else $error("byte count not cleared after last byte");

  // Input stalls only behind a held last byte and a blocked result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q && in_last_q && out_valid_q && !m_axis_tready_i)
    else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire

// ===== tb/crc32_result_checker.sv =====
// Checker for the CRC-32 message check unit: follows accepted bytes, predicts
// each message's check value and compares it with the output stream.
// Depends on crc32_pkg for the widths, polynomial and byte count limit.
`timescale 1ns / 1ps

module crc32_result_checker (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         byte_valid_i,
  input  wire                         byte_ready_i,
  input  wire  [crc32_pkg::ByteW-1:0] byte_data_i,
  input  wire                         byte_last_i,
  input  wire                         crc_valid_i,
  input  wire                         crc_ready_i,
  input  wire  [crc32_pkg::CrcW-1:0]  crc_data_i,
  output logic [31:0]                 mismatch_count_o,
  output logic [31:0]                 pending_count_o,
  output logic [31:0]                 checked_count_o
);

  // Check values predicted for messages that have been fully accepted.
  logic [crc32_pkg::CrcW-1:0] crc_expected_q[$];

  // Running state of the message being taken in.
  logic [crc32_pkg::CrcW-1:0] msg_acc;
  logic [crc32_pkg::CntW-1:0] msg_bytes;

  logic [crc32_pkg::CrcW-1:0] next_word;
  logic [crc32_pkg::CntW-1:0] next_bytes;
  logic [crc32_pkg::CrcW-1:0] want_crc;

  // Remainder of a top byte after eight division steps, most significant first.
  function automatic logic [crc32_pkg::CrcW-1:0] top_byte_remainder(
    input logic [crc32_pkg::ByteW-1:0] top
  );
    logic [crc32_pkg::CrcW-1:0] rem;
    rem = {top, 24'h000000};
    repeat (8) begin
      if (rem[crc32_pkg::CrcW-1]) begin
        rem = (rem << 1) ^ crc32_pkg::CrcPoly;
      end else begin
        rem = rem << 1;
      end
    end
    return rem;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: crc check error: %s", $time, what);
    mismatch_count_o = mismatch_count_o + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mismatch_count_o = '0;
      msg_acc         <= '0;
      msg_bytes       <= '0;
      pending_count_o <= '0;
      checked_count_o <= '0;
      crc_expected_q.delete();
    end else begin
      // Compare a delivered check value with the oldest prediction.
      if (crc_valid_i && crc_ready_i) begin
        if (crc_expected_q.size() == 0) begin
          report_mismatch($sformatf("check value %08h with no message pending",
                                    crc_data_i));
        end else begin
          want_crc = crc_expected_q.pop_front();
          if (crc_data_i !== want_crc) begin
            report_mismatch($sformatf("crc_value %08h, expected %08h",
                                      crc_data_i, want_crc));
          end
        end
        checked_count_o <= checked_count_o + 1;
      end

      // Advance the prediction on each accepted byte.
      if (byte_valid_i && byte_ready_i) begin
        if (msg_bytes < crc32_pkg::CntFull) begin
          // Still gathering the first four bytes big-endian.
          next_word  = {msg_acc[23:0], byte_data_i};
          next_bytes = msg_bytes + crc32_pkg::CntW'(1);
          if (byte_last_i) begin
            // A short message is padded with zero bytes; the two inversions cancel.
            crc_expected_q.push_back(next_word << (8 * (4 - int'(next_bytes))));
            msg_acc   <= '0;
            msg_bytes <= '0;
          end else begin
            msg_acc   <= (next_bytes == crc32_pkg::CntFull) ? ~next_word : next_word;
            msg_bytes <= next_bytes;
          end
        end else begin
          next_word = {msg_acc[23:0], byte_data_i} ^ top_byte_remainder(msg_acc[31:24]);
          if (byte_last_i) begin
            crc_expected_q.push_back(~next_word);
            msg_acc   <= '0;
            msg_bytes <= '0;
          end else begin
            msg_acc   <= next_word;
            msg_bytes <= crc32_pkg::CntFull;
          end
        end
      end

      pending_count_o <= crc_expected_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the CRC-32 message check testbench: clock, reset, byte stimulus and
// the output-side ready pattern. Needs the unit, crc32_pkg and crc32_result_checker.
`timescale 1ns / 1ps

module tb_top;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_valid = 1'b0;
  logic [crc32_pkg::ByteW-1:0]  s_data = '0;
  logic                         s_last = 1'b0;
  logic                         m_ready = 1'b0;
  logic                         s_ready;
  logic                         m_valid;
  logic [crc32_pkg::CrcW-1:0]   m_data;

  logic [31:0] mismatches;
  logic [31:0] crc_pending;
  logic [31:0] crc_checked;

  // Idling mix, in per cent of cycles, for each side.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Raised once to make the receiver hold off for a long stretch.
  logic long_stall_req = 1'b0;

  int bytes_sent = 0;
  int msgs_sent = 0;
  int longest_msg = 0;

  crc32_msb_first_message_check_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  crc32_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .byte_valid_i     (s_valid),
    .byte_ready_i     (s_ready),
    .byte_data_i      (s_data),
    .byte_last_i      (s_last),
    .crc_valid_i      (m_valid),
    .crc_ready_i      (m_ready),
    .crc_data_i       (m_data),
    .mismatch_count_o (mismatches),
    .pending_count_o  (crc_pending),
    .checked_count_o  (crc_checked)
  );

  initial begin
    forever begin
      #10 clk_i = ~clk_i;
    end
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: random ready, with one long hold-off counted here.
  initial begin : sink
    int  stall_left;
    bit  stall_taken;
    stall_left  = 0;
    stall_taken = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_stall_req && !stall_taken) begin
        stall_left  = 150;
        stall_taken = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offer one byte, idling at random first, and return once it is accepted.
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= value;
    s_last  <= is_last;
    do begin
      @(posedge clk_i);
    end while (!s_ready);
    bytes_sent++;
  endtask

  task automatic send_message(input logic [7:0] msg[$]);
    for (int i = 0; i < msg.size(); i++) begin
      send_byte(msg[i], i == msg.size() - 1);
    end
    msgs_sent++;
    if (msg.size() > longest_msg) begin
      longest_msg = msg.size();
    end
  endtask

  // Stop offering and wait until every predicted check value has come out.
  task automatic wait_drained();
    s_valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (crc_pending != 0);
  endtask

  task automatic send_random_message();
    logic [7:0] msg[$];
    int         len;
    int         roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      len = $urandom_range(1, 4);
    end else if (roll < 90) begin
      len = $urandom_range(5, 16);
    end else begin
      len = $urandom_range(17, 64);
    end
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        msg.push_back(8'h00);
      end else if (roll < 20) begin
        msg.push_back(8'hFF);
      end else begin
        msg.push_back(8'($urandom_range(0, 255)));
      end
    end
    send_message(msg);
  endtask

  initial begin : stimulus
    int phase_start;
    send_idle_pct = 13;
    recv_idle_pct = 62;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed messages: one to three bytes (zero padded), exactly four,
    // just past four, all ones, and the usual nine-character check string.
    send_message('{8'h00});
    send_message('{8'hFF});
    send_message('{8'hA5, 8'h5A});
    send_message('{8'hFF, 8'hFF, 8'hFF});
    send_message('{8'h01, 8'h02, 8'h03, 8'h04});
    send_message('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_message('{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39});
    wait_drained();

    // Random messages under three idling mixes.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 560) begin
        // Partway into the first mix the receiver holds off while bytes keep coming.
        if (phase == 0 && !long_stall_req && bytes_sent - phase_start > 100) begin
          long_stall_req <= 1'b1;
        end
        send_random_message();
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    $display("Covered %0d messages of 1 to %0d bytes (%0d bytes, %0d check values)",
             msgs_sent, longest_msg, bytes_sent, crc_checked);
    $display("under two idling mixes, a full-rate stretch and a long output hold-off.");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/crc32_pkg.sv
src/crc32_msb_first_message_check_unit.sv
tb/crc32_result_checker.sv
tb/tb_top.sv
